// ----- sv/tpc_pkg.sv -----
package tpc_pkg;

  // default number of fraction bits of the fixed point datapath
  localparam int unsigned FracBitsDef = 16;

  // saturation ceiling of unsigned intermediates
  localparam logic [63:0] Cap = 64'h7FFF_FFFF_FFFF_FFFF;

  // item commands
  typedef enum logic [1:0] {
    CMD_PTAT  = 2'd0,
    CMD_COMP  = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PTAT_REF   = 3'd0,
    REG_PTAT_LIN   = 3'd1,
    REG_PTAT_SQ    = 3'd2,
    REG_EMISSIVITY = 3'd3,
    REG_COMP_OFS   = 3'd4,
    REG_COMP_SLOPE = 3'd5,
    REG_GRADIENT   = 3'd6,
    REG_SLOPE_SHFT = 3'd7
  } reg_e;

  // status of a shared arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- sv/tpc_in_if.sv -----
interface tpc_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [15:0] raw_sample;
  logic signed [7:0]  pixel_offset;
  logic signed [7:0]  pixel_slope;
  logic        [31:0] pixel_sensitivity;

  modport source (
    output valid, cmd, raw_sample, pixel_offset, pixel_slope, pixel_sensitivity,
    input  ready
  );
  modport sink (
    input  valid, cmd, raw_sample, pixel_offset, pixel_slope, pixel_sensitivity,
    output ready
  );
endinterface

// ----- sv/tpc_out_if.sv -----
interface tpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_tenths;
  logic               is_ambient;
  logic               invalid;

  modport source (
    output valid, temp_tenths, is_ambient, invalid,
    input  ready
  );
  modport sink (
    input  valid, temp_tenths, is_ambient, invalid,
    output ready
  );
endinterface

// ----- sv/tpc_mul.sv -----
module tpc_mul import tpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] prod_o,
  output unit_stat_t   stat_o
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   step_q;
  logic         busy_q, done_q;
  logic [63:0]  pp_q, pp_d;
  logic [1:0]   sh_q, sh_d;
  logic [127:0] acc_q, acc_add;

  // one 32x32 partial product per cycle, halves picked by the step
  always_comb begin
    logic [31:0] opa, opb;
    opa  = step_q[1] ? a_q[63:32] : a_q[31:0];
    opb  = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp_d = opa * opb;
    sh_d = {1'b0, step_q[1]} + {1'b0, step_q[0]};
  end

  // place the registered partial product at its weight
  always_comb begin
    case (sh_q)
      2'd0:    acc_add = {64'd0, pp_q};
      2'd1:    acc_add = {32'd0, pp_q, 32'd0};
      default: acc_add = {pp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= pp_d;
      sh_q <= sh_d;
      if (step_q != 3'd0) begin
        acc_q <= acc_q + acc_add;
      end
    end
  end

  assign prod_o = acc_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/tpc_divsqrt.sv -----
module tpc_divsqrt import tpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [63:0] x_i,
  input  logic        pad_i,
  input  logic [6:0]  iters_i,
  input  logic [47:0] d_i,
  output logic [63:0] q_o,
  output logic        rem_nz_o,
  output unit_stat_t  stat_o
);

  logic [64:0] sr_q;
  logic [63:0] rem_q, root_q;
  logic [47:0] d_q;
  logic [6:0]  cnt_q;
  logic        sqrt_q, sat_q, busy_q, done_q;

  logic [63:0] cand, subtr, diff;
  logic        ge;

  // shared compare and subtract for both recurrences
  always_comb begin
    if (sqrt_q) begin
      cand  = {rem_q[61:0], sr_q[64], sr_q[63]};
      subtr = {root_q[61:0], 2'b01};
    end else begin
      cand  = {rem_q[62:0], sr_q[64]};
      subtr = {16'd0, d_q};
    end
    ge   = cand >= subtr;
    diff = cand - subtr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit or one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sr_q   <= pad_i ? {1'b0, x_i} : {x_i, 1'b0};
      rem_q  <= '0;
      root_q <= '0;
      sat_q  <= 1'b0;
      sqrt_q <= sqrt_i;
      d_q    <= d_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : cand;
      if (sqrt_q) begin
        sr_q   <= {sr_q[62:0], 2'b00};
        root_q <= {root_q[62:0], ge};
      end else begin
        sr_q <= {sr_q[63:0], 1'b0};
        if (!sat_q) begin
          if (root_q > (Cap >> 1)) begin
            sat_q <= 1'b1;
          end else begin
            root_q <= {root_q[62:0], ge};
          end
        end
      end
    end
  end

  assign q_o      = sat_q ? Cap : root_q;
  assign rem_nz_o = |rem_q;
  assign stat_o   = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/thermal_pixel_compensation.sv -----
// Thermopile pixel compensation. A PTAT item solves the ambient quadratic, keeps
// the ambient temperature and returns it in tenths of a degree; a compensation
// pixel item only updates the stored compensation value; an IR pixel item returns
// its object temperature in tenths of a degree, floored and saturated, with the
// invalid flag for a negative root argument or a zero divisor. Items are taken
// one at a time and all heavy arithmetic runs through one 32x32 multiplier
// and one bit-serial divide and square root unit (one bit per cycle); an IR pixel
// runs a 119-bit quotient and two roots through that unit. Results leave through
// an output register, so a finished result does not hold up the next item.
module thermal_pixel_compensation import tpc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  tpc_in_if.sink       pix_i,
  tpc_out_if.source    res_o
);

  localparam logic signed [63:0] One    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] AmbOfs = 64'sd25 * One;
  localparam logic signed [63:0] Kelvin = (64'sd27315 * One + 64'sd50) / 64'sd100;
  localparam int unsigned        SqAmbIt = (64 + 2 * FRAC_BITS) / 2;
  localparam int unsigned        PixPadI = FRAC_BITS % 2;
  localparam int unsigned        SqPixIt = (64 + FRAC_BITS + PixPadI) / 2;
  localparam logic               PixPad  = PixPadI[0];

  typedef enum logic [3:0] {
    S_IDLE, S_A_LIN, S_A_SQ, S_A_ROOT, S_A_DIV,
    S_P_SLOPE, S_P_GRAD, S_P_DEN, S_P_DIV, S_P_T2, S_P_T4,
    S_P_R2, S_P_R4, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic        [15:0] ptat_ref_q, lin_q, sq_q, emis_q;
  logic signed [7:0]  coff_q, cslope_q, tgc_q;
  logic        [4:0]  shift_q;

  // kept state
  logic signed [31:0] amb_q, cpc_q;

  // item and working registers
  logic        [1:0]  cmd_q;
  logic        [15:0] raw_q;
  logic signed [7:0]  off_q;
  logic        [31:0] alpha_q;
  logic signed [63:0] acc_q, v_q;
  logic        [63:0] term_q;
  logic               neg_q;

  // staged and output result
  logic signed [15:0] res_t_q, out_t_q;
  logic               res_amb_q, res_bad_q, out_amb_q, out_bad_q, out_valid_q;

  // unit control
  logic               mul_go_q, ds_go_q, ds_sqrt_q, ds_pad_q;
  logic        [63:0] mul_a_q, mul_b_q, ds_x_q;
  logic        [6:0]  ds_it_q;
  logic        [47:0] ds_d_q;
  logic        [127:0] mul_prod;
  logic        [63:0] ds_q;
  logic               ds_rem_nz;
  unit_stat_t         mul_st, ds_st;

  tpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .prod_o  (mul_prod),
    .stat_o  (mul_st)
  );

  tpc_divsqrt u_ds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ds_go_q),
    .sqrt_i   (ds_sqrt_q),
    .x_i      (ds_x_q),
    .pad_i    (ds_pad_q),
    .iters_i  (ds_it_q),
    .d_i      (ds_d_q),
    .q_o      (ds_q),
    .rem_nz_o (ds_rem_nz),
    .stat_o   (ds_st)
  );

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    abs64 = x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  // floor(x*10 / 2^FRAC_BITS) saturated to 16 bits
  function automatic logic signed [15:0] tenths(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = ((x <<< 3) + (x <<< 1)) >>> FRAC_BITS;
    if (s > 64'sd32767) begin
      tenths = 16'sh7FFF;
    end else if (s < -64'sd32768) begin
      tenths = 16'sh8000;
    end else begin
      tenths = s[15:0];
    end
  endfunction

  // product shifted down by the fraction, capped
  function automatic logic [63:0] capshr(input logic [127:0] p);
    logic [127:0] s;
    s = p >> FRAC_BITS;
    capshr = (|s[127:63]) ? Cap : s[63:0];
  endfunction

  // datapath around the units
  logic signed [63:0] prod_s, amb_x, rel_amb, raw_x, off_x, oc_c, v_c, qv_c, n_c;
  logic signed [63:0] tk_c, lin_sh;
  logic        [63:0] qd_c, t_c, rad_c;
  logic signed [63:0] rel_c;
  logic signed [31:0] amb_c, rel_sat;
  logic signed [16:0] diff_c;
  logic signed [7:0]  slope_in;
  logic        [64:0] sum_c;
  logic               rad_bad;

  always_comb begin
    prod_s   = neg_q ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
    amb_x    = {{32{amb_q[31]}}, amb_q};
    rel_amb  = amb_x - AmbOfs;
    raw_x    = {{48{raw_q[15]}}, raw_q};
    off_x    = {{56{off_q[7]}}, off_q};
    oc_c     = (raw_x <<< FRAC_BITS) - ((off_x <<< FRAC_BITS) + (prod_s >>> shift_q));
    v_c      = acc_q - (prod_s >>> 5);
    qv_c     = acc_q - (prod_s <<< 2);
    lin_sh   = $signed({48'd0, lin_q}) <<< FRAC_BITS;
    n_c      = ($signed(ds_q) - lin_sh) <<< 9;
    qd_c     = ds_q + {63'd0, neg_q & ds_rem_nz};
    rel_c    = neg_q ? -$signed(qd_c) : $signed(qd_c);
    rel_sat  = sat32(rel_c);
    amb_c    = sat32({{32{rel_sat[31]}}, rel_sat} + AmbOfs);
    diff_c   = $signed({1'b0, ptat_ref_q}) - $signed({1'b0, raw_q});
    tk_c     = amb_x + Kelvin;
    slope_in = (cmd_e'(pix_i.cmd) == CMD_COMP) ? cslope_q : pix_i.pixel_slope;
    t_c      = capshr(mul_prod);
    sum_c    = {1'b0, t_c} + {1'b0, term_q};
    rad_bad  = v_q[63] && (term_q > t_c);
    if (v_q[63]) begin
      rad_c = t_c - term_q;
    end else begin
      rad_c = (sum_c > {1'b0, Cap}) ? Cap : sum_c[63:0];
    end
  end

  assign pix_i.ready = (state_q == S_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptat_ref_q <= '0;
      lin_q      <= '0;
      sq_q       <= 16'd1;
      emis_q     <= 16'd32768;
      coff_q     <= '0;
      cslope_q   <= '0;
      tgc_q      <= '0;
      shift_q    <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_PTAT_REF:   ptat_ref_q <= cfg_data_i;
        REG_PTAT_LIN:   lin_q      <= cfg_data_i;
        REG_PTAT_SQ:    sq_q       <= cfg_data_i;
        REG_EMISSIVITY: emis_q     <= cfg_data_i;
        REG_COMP_OFS:   coff_q     <= cfg_data_i[7:0];
        REG_COMP_SLOPE: cslope_q   <= cfg_data_i[7:0];
        REG_GRADIENT:   tgc_q      <= cfg_data_i[7:0];
        REG_SLOPE_SHFT: shift_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_go_q    <= 1'b0;
      ds_go_q     <= 1'b0;
      out_valid_q <= 1'b0;
      amb_q       <= '0;
      cpc_q       <= '0;
    end else begin
      mul_go_q <= 1'b0;
      ds_go_q  <= 1'b0;
      // the final step reloads the output register itself
      if (out_valid_q && res_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            cmd_q   <= pix_i.cmd;
            raw_q   <= pix_i.raw_sample;
            alpha_q <= pix_i.pixel_sensitivity;
            off_q   <= (cmd_e'(pix_i.cmd) == CMD_COMP) ? coff_q : pix_i.pixel_offset;
            case (cmd_e'(pix_i.cmd))
              CMD_PTAT: begin
                mul_a_q  <= {48'd0, lin_q};
                mul_b_q  <= {48'd0, lin_q};
                neg_q    <= 1'b0;
                mul_go_q <= 1'b1;
                state_q  <= S_A_LIN;
              end
              CMD_COMP, CMD_PIXEL: begin
                mul_a_q  <= abs64({{56{slope_in[7]}}, slope_in});
                mul_b_q  <= abs64(rel_amb);
                neg_q    <= slope_in[7] ^ rel_amb[63];
                mul_go_q <= 1'b1;
                state_q  <= S_P_SLOPE;
              end
              default: ;
            endcase
          end
        end
        S_A_LIN: begin
          if (mul_st.done) begin
            acc_q    <= $signed(mul_prod[63:0]);
            mul_a_q  <= {48'd0, sq_q};
            mul_b_q  <= abs64({{47{diff_c[16]}}, diff_c});
            neg_q    <= diff_c[16];
            mul_go_q <= 1'b1;
            state_q  <= S_A_SQ;
          end
        end
        S_A_SQ: begin
          if (mul_st.done) begin
            if (sq_q == 16'd0 || qv_c[63]) begin
              res_t_q   <= '0;
              res_amb_q <= 1'b1;
              res_bad_q <= 1'b1;
              state_q   <= S_FIN;
            end else begin
              ds_x_q    <= qv_c;
              ds_sqrt_q <= 1'b1;
              ds_pad_q  <= 1'b0;
              ds_it_q   <= 7'(SqAmbIt);
              ds_go_q   <= 1'b1;
              state_q   <= S_A_ROOT;
            end
          end
        end
        S_A_ROOT: begin
          if (ds_st.done) begin
            ds_x_q    <= abs64(n_c);
            neg_q     <= n_c[63];
            ds_d_q    <= {32'd0, sq_q};
            ds_sqrt_q <= 1'b0;
            ds_pad_q  <= 1'b0;
            ds_it_q   <= 7'd64;
            ds_go_q   <= 1'b1;
            state_q   <= S_A_DIV;
          end
        end
        S_A_DIV: begin
          if (ds_st.done) begin
            amb_q     <= amb_c;
            res_t_q   <= tenths({{32{amb_c[31]}}, amb_c});
            res_amb_q <= 1'b1;
            res_bad_q <= 1'b0;
            state_q   <= S_FIN;
          end
        end
        S_P_SLOPE: begin
          if (mul_st.done) begin
            if (cmd_e'(cmd_q) == CMD_COMP) begin
              cpc_q   <= sat32(oc_c);
              state_q <= S_IDLE;
            end else begin
              acc_q    <= oc_c;
              mul_a_q  <= abs64({{56{tgc_q[7]}}, tgc_q});
              mul_b_q  <= abs64({{32{cpc_q[31]}}, cpc_q});
              neg_q    <= tgc_q[7] ^ cpc_q[31];
              mul_go_q <= 1'b1;
              state_q  <= S_P_GRAD;
            end
          end
        end
        S_P_GRAD: begin
          if (mul_st.done) begin
            v_q <= v_c;
            if (emis_q == 16'd0 || alpha_q == 32'd0) begin
              res_t_q   <= '0;
              res_amb_q <= 1'b0;
              res_bad_q <= 1'b1;
              state_q   <= S_FIN;
            end else begin
              mul_a_q  <= {48'd0, emis_q};
              mul_b_q  <= {32'd0, alpha_q};
              neg_q    <= 1'b0;
              mul_go_q <= 1'b1;
              state_q  <= S_P_DEN;
            end
          end
        end
        S_P_DEN: begin
          if (mul_st.done) begin
            ds_x_q    <= abs64(v_q);
            ds_d_q    <= mul_prod[47:0];
            ds_sqrt_q <= 1'b0;
            ds_pad_q  <= 1'b0;
            ds_it_q   <= 7'd119;
            ds_go_q   <= 1'b1;
            state_q   <= S_P_DIV;
          end
        end
        S_P_DIV: begin
          if (ds_st.done) begin
            term_q   <= ds_q;
            mul_a_q  <= abs64(tk_c);
            mul_b_q  <= abs64(tk_c);
            mul_go_q <= 1'b1;
            state_q  <= S_P_T2;
          end
        end
        S_P_T2: begin
          if (mul_st.done) begin
            mul_a_q  <= t_c;
            mul_b_q  <= t_c;
            mul_go_q <= 1'b1;
            state_q  <= S_P_T4;
          end
        end
        S_P_T4: begin
          if (mul_st.done) begin
            if (rad_bad) begin
              res_t_q   <= '0;
              res_amb_q <= 1'b0;
              res_bad_q <= 1'b1;
              state_q   <= S_FIN;
            end else begin
              ds_x_q    <= rad_c;
              ds_sqrt_q <= 1'b1;
              ds_pad_q  <= PixPad;
              ds_it_q   <= 7'(SqPixIt);
              ds_go_q   <= 1'b1;
              state_q   <= S_P_R2;
            end
          end
        end
        S_P_R2: begin
          if (ds_st.done) begin
            ds_x_q  <= ds_q;
            ds_go_q <= 1'b1;
            state_q <= S_P_R4;
          end
        end
        S_P_R4: begin
          if (ds_st.done) begin
            res_t_q   <= tenths($signed(ds_q) - Kelvin);
            res_amb_q <= 1'b0;
            res_bad_q <= 1'b0;
            state_q   <= S_FIN;
          end
        end
        S_FIN: begin
          // hand the result to the output register once it is free
          if (!out_valid_q || res_o.ready) begin
            out_t_q     <= res_t_q;
            out_amb_q   <= res_amb_q;
            out_bad_q   <= res_bad_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.temp_tenths = out_t_q;
  assign res_o.is_ambient  = out_amb_q;
  assign res_o.invalid     = out_bad_q;

`ifndef SYNTHESIS
  // both shared units are never at work at once
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_st.busy && ds_st.busy))
    else $error("multiplier and divide/root unit busy together");

  // no new item is taken while a unit still works on the last one
  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready |-> (!mul_st.busy && !ds_st.busy))
    else $error("input ready while a unit is busy");

  // a result appears only from the final sequencer step
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside the final step");
`endif

endmodule
